// ===== rtl/gpmc_pkg.sv =====
`default_nettype none

package gpmc_pkg;

    localparam int unsigned FLAG_W   = 7;
    localparam int unsigned STATUS_W = 16;
    localparam int unsigned ACCUM_W  = 24;
    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned CODE_W   = 4;
    localparam int unsigned REQ_W    = 3;
    localparam int unsigned CTRL_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // mode flag bit positions
    localparam int unsigned FL_INIT = 0;
    localparam int unsigned FL_READ = 1;
    localparam int unsigned FL_IDLE = 2;
    localparam int unsigned FL_LP   = 3;
    localparam int unsigned FL_LPEN = 4;
    localparam int unsigned FL_LPEX = 5;
    localparam int unsigned FL_RST  = 6;

    localparam logic [FLAG_W-1:0]    FLAGS_RESET     = 7'h03;
    localparam logic [STATUS_W-1:0]  FAULT_MASK_RESET = 16'h001A;
    localparam logic [ACCUM_W-1:0]   WAKE_DELAY_RESET = 24'd150000;
    localparam logic [CODE_W-1:0]    OVERFLOW_RESET   = 4'd4;
    localparam logic [ACCUM_W-1:0]   ACCUM_MAX        = {ACCUM_W{1'b1}};

    // command codes
    localparam logic [REQ_W-1:0] REQ_NONE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_IDLE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LPEN  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LPEX  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RESET = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW   = 2'd2;

    // reported state codes
    localparam logic [CTRL_W-1:0] CODE_INIT  = 3'd0;
    localparam logic [CTRL_W-1:0] CODE_READ  = 3'd1;
    localparam logic [CTRL_W-1:0] CODE_IDLE  = 3'd2;
    localparam logic [CTRL_W-1:0] CODE_LPEN  = 3'd3;
    localparam logic [CTRL_W-1:0] CODE_LPEX  = 3'd4;
    localparam logic [CTRL_W-1:0] CODE_FAULT = 3'd5;
    localparam logic [CTRL_W-1:0] CODE_RESET = 3'd6;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_IDLE  = 7'b0000100,
        S_LPEN  = 7'b0001000,
        S_LPEX  = 7'b0010000,
        S_FAULT = 7'b0100000,
        S_RESET = 7'b1000000
    } t_mode_state;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic                 tx_ready;
        logic [CODE_W-1:0]    data_status;
        logic [CODE_W-1:0]    flush_status;
        logic [ELAPSED_W-1:0] elapsed_us;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] fault_mask;
        logic [ACCUM_W-1:0]  wake_delay_us;
        logic [CODE_W-1:0]   overflow_code;
    } t_cfg;

    typedef struct packed {
        t_mode_state         mode_state;
        logic [FLAG_W-1:0]   mode_flags;
        logic [STATUS_W-1:0] status_onehot;
        logic [STATUS_W-1:0] fault_hold;
        logic [ACCUM_W-1:0]  wake_accum;
        logic                pin_level;
    } t_ctx;

    typedef struct packed {
        logic [CTRL_W-1:0]   ctrl_state;
        logic                low_power;
        logic [STATUS_W-1:0] fault_word;
        logic                wake_pin;
        logic                read_request;
        logic                flush_request;
    } t_result;

    function automatic logic [CTRL_W-1:0] state_code(input t_mode_state s);
        logic [CTRL_W-1:0] c;
        unique case (s)
            S_INIT:  c = CODE_INIT;
            S_READ:  c = CODE_READ;
            S_IDLE:  c = CODE_IDLE;
            S_LPEN:  c = CODE_LPEN;
            S_LPEX:  c = CODE_LPEX;
            S_FAULT: c = CODE_FAULT;
            S_RESET: c = CODE_RESET;
            default: c = CODE_INIT;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gpmc_step.sv =====
`default_nettype none

module gpmc_step
    import gpmc_pkg::*;
(
    input  wire t_ctx    i_ctx,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_ctx         o_ctx,
    output t_result      o_result
);

    logic [FLAG_W-1:0]   w_flags;
    logic [STATUS_W-1:0] w_status;
    logic [STATUS_W-1:0] w_hold;
    logic                w_flt;
    t_mode_state         w_next;
    logic [ACCUM_W:0]    w_sum;
    logic [ACCUM_W-1:0]  w_accum;
    logic                w_rd;
    logic                w_fl;

    // command, then pending status into fault code
    always_comb begin
        w_flags = i_ctx.mode_flags;
        case (i_item.req_type)
            REQ_READ: begin
                w_flags[FL_READ] = 1'b1;
                w_flags[FL_IDLE] = 1'b0;
            end
            REQ_IDLE: begin
                w_flags[FL_IDLE] = 1'b1;
                w_flags[FL_READ] = 1'b0;
            end
            REQ_LPEN:  w_flags[FL_LPEN] = 1'b1;
            REQ_LPEX:  w_flags[FL_LPEX] = 1'b1;
            REQ_RESET: w_flags[FL_RST]  = 1'b1;
            default: ;
        endcase
        if (i_ctx.status_onehot != '0) begin
            w_hold   = i_ctx.status_onehot & i_cfg.fault_mask;
            w_status = '0;
        end else begin
            w_hold   = i_ctx.fault_hold;
            w_status = i_ctx.status_onehot;
        end
        w_flt = (w_hold != '0);
    end

    always_comb begin
        unique case (i_ctx.mode_state)
            S_INIT: begin
                if (w_flt)                  w_next = S_FAULT;
                else if (w_flags[FL_INIT])  w_next = S_INIT;
                else if (w_flags[FL_READ])  w_next = S_READ;
                else if (w_flags[FL_IDLE])  w_next = S_IDLE;
                else                        w_next = S_INIT;
            end
            S_READ: begin
                if (w_flt)                  w_next = S_FAULT;
                else if (w_flags[FL_LPEN])  w_next = S_LPEN;
                else if (w_flags[FL_IDLE])  w_next = S_IDLE;
                else                        w_next = S_READ;
            end
            S_IDLE: begin
                if (w_flt)                  w_next = S_FAULT;
                else if (w_flags[FL_LP])    w_next = w_flags[FL_LPEX] ? S_LPEX : S_IDLE;
                else if (w_flags[FL_LPEN])  w_next = S_LPEN;
                else if (w_flags[FL_READ])  w_next = S_READ;
                else                        w_next = S_IDLE;
            end
            S_LPEN:  w_next = S_IDLE;
            S_LPEX: begin
                if (w_flt)                  w_next = S_FAULT;
                else if (!w_flags[FL_LP])   w_next = w_flags[FL_READ] ? S_READ : S_IDLE;
                else                        w_next = S_LPEX;
            end
            S_FAULT: w_next = (w_flags[FL_RST] || !w_flt) ? S_RESET : S_FAULT;
            S_RESET: w_next = S_INIT;
            default: w_next = S_INIT;
        endcase
    end

    // state action
    always_comb begin
        o_ctx               = i_ctx;
        o_ctx.mode_state    = w_next;
        o_ctx.mode_flags    = w_flags;
        o_ctx.status_onehot = w_status;
        o_ctx.fault_hold    = w_hold;
        w_rd  = 1'b0;
        w_fl  = 1'b0;
        w_sum = {1'b0, i_ctx.wake_accum} + {{(ACCUM_W + 1 - ELAPSED_W){1'b0}}, i_item.elapsed_us};
        w_accum = w_sum[ACCUM_W] ? ACCUM_MAX : w_sum[ACCUM_W-1:0];
        unique case (w_next)
            S_INIT: begin
                o_ctx.mode_flags[FL_INIT] = 1'b0;
                o_ctx.mode_flags[FL_RST]  = 1'b0;
            end
            S_READ: begin
                if (i_item.tx_ready) begin
                    o_ctx.status_onehot = STATUS_W'(1) << i_item.data_status;
                    w_rd = 1'b1;
                end
            end
            S_LPEN: begin
                o_ctx.pin_level           = 1'b0;
                o_ctx.mode_flags[FL_LP]   = 1'b1;
                o_ctx.mode_flags[FL_LPEN] = 1'b0;
            end
            S_LPEX: begin
                o_ctx.pin_level  = 1'b1;
                o_ctx.wake_accum = w_accum;
                if (w_accum >= i_cfg.wake_delay_us) begin
                    o_ctx.wake_accum    = '0;
                    w_fl                = 1'b1;
                    o_ctx.status_onehot = STATUS_W'(1) << i_item.flush_status;
                    if (i_item.flush_status == i_cfg.overflow_code) begin
                        o_ctx.mode_flags[FL_LP]   = 1'b0;
                        o_ctx.mode_flags[FL_LPEX] = 1'b0;
                    end
                end
            end
            S_FAULT: begin
                o_ctx.mode_flags[FL_LP]   = 1'b0;
                o_ctx.mode_flags[FL_LPEN] = 1'b0;
                o_ctx.mode_flags[FL_LPEX] = 1'b0;
                o_ctx.wake_accum          = '0;
            end
            S_RESET: o_ctx.fault_hold = '0;
            default: ;
        endcase
    end

    always_comb begin
        o_result.ctrl_state    = state_code(o_ctx.mode_state);
        o_result.low_power     = o_ctx.mode_flags[FL_LP];
        o_result.fault_word    = o_ctx.fault_hold;
        o_result.wake_pin      = o_ctx.pin_level;
        o_result.read_request  = w_rd;
        o_result.flush_request = w_fl;
    end

endmodule

`default_nettype wire

// ===== rtl/gnss_power_mode_controller.sv =====
`default_nettype none

// Power-mode controller for a receiver module: each accepted input transaction is one
// controller step (command, device ready line, read and flush status codes, elapsed
// microseconds) and yields exactly one result transaction with the new state, the
// low-power flag, the masked fault code, the wake-pin level and the read and flush
// strobes. Steps are taken one per clock while the output side keeps up: a transaction is
// captured in the input register, and the step logic reads it from there and writes
// the result into the output register. The output register stalls the step stage only
// when it is full and not being taken. Configuration writes are always taken (cfg_ready
// is held high).
module gnss_power_mode_controller
    import gpmc_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // [0] tx_ready, [4:1] data_status, [8:5] flush_status, [24:9] elapsed_us
    input  wire  [31:0]          s_axis_tdata,
    // [2:0] req_type
    input  wire  [REQ_W-1:0]     s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // [2:0] ctrl_state, [3] low_power, [19:4] fault_word, [20] wake_pin,
    // [21] read_request, [22] flush_request
    output logic [23:0]          m_axis_tdata,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_ctx    r_ctx;
    t_ctx    n_ctx;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    w_adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fault_mask    <= FAULT_MASK_RESET;
            r_cfg.wake_delay_us <= WAKE_DELAY_RESET;
            r_cfg.overflow_code <= OVERFLOW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FAULT_MASK: r_cfg.fault_mask    <= i_cfg_data[STATUS_W-1:0];
                CFG_WAKE_DELAY: r_cfg.wake_delay_us <= i_cfg_data[ACCUM_W-1:0];
                CFG_OVERFLOW:   r_cfg.overflow_code <= i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.req_type     <= s_axis_tuser;
            r_item.tx_ready     <= s_axis_tdata[0];
            r_item.data_status  <= s_axis_tdata[4:1];
            r_item.flush_status <= s_axis_tdata[8:5];
            r_item.elapsed_us   <= s_axis_tdata[24:9];
        end
    end

    gpmc_step u_step (
        .i_ctx    (r_ctx),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_ctx    (n_ctx),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.mode_state    <= S_INIT;
            r_ctx.mode_flags    <= FLAGS_RESET;
            r_ctx.status_onehot <= '0;
            r_ctx.fault_hold    <= '0;
            r_ctx.wake_accum    <= '0;
            r_ctx.pin_level     <= 1'b1;
        end else if (w_adv) begin
            r_ctx <= n_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.flush_request, r_out.read_request, r_out.wake_pin,
                            r_out.fault_word, r_out.low_power, r_out.ctrl_state};

`ifndef NO_ASSERTIONS
    // a step performs at most one device read
    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.read_request && r_out.flush_request))
        else $error("read and flush strobes in the same step");

    // flush reads only happen in low-power exit
    a_flush_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.flush_request) |-> (r_out.ctrl_state == CODE_LPEX))
        else $error("flush strobe outside low-power exit");

    // fault handling drops low power, reset clears the fault code
    a_fault_lp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ctrl_state == CODE_FAULT) |-> !r_out.low_power)
        else $error("low power held in fault state");

    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ctrl_state == CODE_RESET) |-> (r_out.fault_word == '0))
        else $error("fault code not cleared in reset state");

    // the step stage never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire

// ===== verif/gpmc_step_checker.sv =====
module gpmc_step_checker
    import gpmc_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step_valid,
    input  wire                  i_step_ready,
    // [0] tx_ready, [4:1] data_status, [8:5] flush_status, [24:9] elapsed_us
    input  wire  [31:0]          i_step_data,
    // [2:0] req_type
    input  wire  [REQ_W-1:0]     i_step_user,
    input  wire                  i_report_valid,
    input  wire                  i_report_ready,
    // [2:0] ctrl_state, [3] low_power, [19:4] fault_word, [20] wake_pin,
    // [21] read_request, [22] flush_request
    input  wire  [23:0]          i_report_data,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    output logic [31:0]          o_mismatches,
    output logic [31:0]          o_outstanding
);

    int mismatches = 0;
    int outstanding = 0;

    // shadow of the controller
    t_cfg                cfg;
    logic [CTRL_W-1:0]   mode;
    logic [FLAG_W-1:0]   flags;
    logic [STATUS_W-1:0] onehot;
    logic [STATUS_W-1:0] hold;
    logic [ACCUM_W-1:0]  accum;
    logic                pin;

    t_result expected_reports[$];

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    function automatic t_result advance_mode(input logic [REQ_W-1:0] req,
                                             input logic tx,
                                             input logic [CODE_W-1:0] rd_code,
                                             input logic [CODE_W-1:0] fl_code,
                                             input logic [ELAPSED_W-1:0] el);
        t_result           r;
        logic [CTRL_W-1:0] nxt;
        logic              flt;
        logic [ACCUM_W:0]  sum;
        r = '0;
        case (req)
            REQ_READ: begin
                flags[FL_READ] = 1'b1;
                flags[FL_IDLE] = 1'b0;
            end
            REQ_IDLE: begin
                flags[FL_IDLE] = 1'b1;
                flags[FL_READ] = 1'b0;
            end
            REQ_LPEN:  flags[FL_LPEN] = 1'b1;
            REQ_LPEX:  flags[FL_LPEX] = 1'b1;
            REQ_RESET: flags[FL_RST] = 1'b1;
            default: ;
        endcase

        // a pending status is filtered once, even when it clears the fault
        if (onehot != '0) begin
            hold   = onehot & cfg.fault_mask;
            onehot = '0;
        end
        flt = (hold != '0);

        nxt = mode;
        case (mode)
            CODE_INIT: begin
                if (flt) nxt = CODE_FAULT;
                else if (flags[FL_INIT]) nxt = CODE_INIT;
                else if (flags[FL_READ]) nxt = CODE_READ;
                else if (flags[FL_IDLE]) nxt = CODE_IDLE;
            end
            CODE_READ: begin
                if (flt) nxt = CODE_FAULT;
                else if (flags[FL_LPEN]) nxt = CODE_LPEN;
                else if (flags[FL_IDLE]) nxt = CODE_IDLE;
            end
            CODE_IDLE: begin
                if (flt) nxt = CODE_FAULT;
                else if (flags[FL_LP]) nxt = flags[FL_LPEX] ? CODE_LPEX : CODE_IDLE;
                else if (flags[FL_LPEN]) nxt = CODE_LPEN;
                else if (flags[FL_READ]) nxt = CODE_READ;
            end
            CODE_LPEN: nxt = CODE_IDLE;
            CODE_LPEX: begin
                if (flt) nxt = CODE_FAULT;
                else if (!flags[FL_LP]) nxt = flags[FL_READ] ? CODE_READ : CODE_IDLE;
            end
            CODE_FAULT: begin
                if (flags[FL_RST] || !flt) nxt = CODE_RESET;
            end
            CODE_RESET: nxt = CODE_INIT;
            default:    nxt = CODE_INIT;
        endcase

        case (nxt)
            CODE_INIT: begin
                flags[FL_INIT] = 1'b0;
                flags[FL_RST]  = 1'b0;
            end
            CODE_READ: begin
                if (tx) begin
                    onehot          = '0;
                    onehot[rd_code] = 1'b1;
                    r.read_request  = 1'b1;
                end
            end
            CODE_LPEN: begin
                pin            = 1'b0;
                flags[FL_LP]   = 1'b1;
                flags[FL_LPEN] = 1'b0;
            end
            CODE_LPEX: begin
                pin = 1'b1;
                sum = {1'b0, accum} + {{(ACCUM_W + 1 - ELAPSED_W){1'b0}}, el};
                accum = sum[ACCUM_W] ? ACCUM_MAX : sum[ACCUM_W-1:0];
                if (accum >= cfg.wake_delay_us) begin
                    accum           = '0;
                    r.flush_request = 1'b1;
                    onehot          = '0;
                    onehot[fl_code] = 1'b1;
                    if (fl_code == cfg.overflow_code) begin
                        flags[FL_LP]   = 1'b0;
                        flags[FL_LPEX] = 1'b0;
                    end
                end
            end
            CODE_FAULT: begin
                flags[FL_LP]   = 1'b0;
                flags[FL_LPEN] = 1'b0;
                flags[FL_LPEX] = 1'b0;
                accum          = '0;
            end
            CODE_RESET: hold = '0;
            default: ;
        endcase
        mode = nxt;

        r.ctrl_state = mode;
        r.low_power  = flags[FL_LP];
        r.fault_word = hold;
        r.wake_pin   = pin;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            cfg.fault_mask    = FAULT_MASK_RESET;
            cfg.wake_delay_us = WAKE_DELAY_RESET;
            cfg.overflow_code = OVERFLOW_RESET;
            mode   = CODE_INIT;
            flags  = FLAGS_RESET;
            onehot = '0;
            hold   = '0;
            accum  = '0;
            pin    = 1'b1;
            expected_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FAULT_MASK: cfg.fault_mask    = i_cfg_data[STATUS_W-1:0];
                    CFG_WAKE_DELAY: cfg.wake_delay_us = i_cfg_data[ACCUM_W-1:0];
                    CFG_OVERFLOW:   cfg.overflow_code = i_cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_report_valid && i_report_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: report %h arrived with no step waiting for it",
                             $time, i_report_data);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("ctrl_state", 32'(want.ctrl_state), 32'(i_report_data[2:0]));
                    check_field("low_power", 32'(want.low_power), 32'(i_report_data[3]));
                    check_field("fault_word", 32'(want.fault_word), 32'(i_report_data[19:4]));
                    check_field("wake_pin", 32'(want.wake_pin), 32'(i_report_data[20]));
                    check_field("read_request", 32'(want.read_request),
                                32'(i_report_data[21]));
                    check_field("flush_request", 32'(want.flush_request),
                                32'(i_report_data[22]));
                end
            end
            if (i_step_valid && i_step_ready) begin
                expected_reports.push_back(advance_mode(i_step_user, i_step_data[0],
                                                        i_step_data[4:1], i_step_data[8:5],
                                                        i_step_data[24:9]));
            end
        end
        outstanding = expected_reports.size();
    end

endmodule

// ===== verif/gnss_power_mode_controller_test.sv =====
module gnss_power_mode_controller_test
    import gpmc_pkg::*;
();

    // command codes the block ignores, and the unmapped register slot
    localparam logic [REQ_W-1:0]     REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0]     REQ_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

    localparam int IDLE_PCT    = 15;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [31:0]           s_data;
    logic [REQ_W-1:0]      s_user;
    logic                  m_valid;
    logic                  m_ready;
    logic [23:0]           m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [31:0]           mismatches;
    logic [31:0]           outstanding;

    logic                  calm;
    int                    hold_asked;
    int                    steps_sent;
    int                    cycles;
    logic [CODE_W-1:0]     ovf_now;

    gnss_power_mode_controller uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    gpmc_step_checker watcher (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_step_valid   (s_valid),
        .i_step_ready   (s_ready),
        .i_step_data    (s_data),
        .i_step_user    (s_user),
        .i_report_valid (m_valid),
        .i_report_ready (m_ready),
        .i_report_data  (m_data),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial cycles = 0;

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin : report_sink
        int holds_done;
        holds_done = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_asked != holds_done) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) begin
                    @(negedge clk);
                    m_ready <= 1'b0;
                end
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [ELAPSED_W-1:0] rand_elapsed();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return {ELAPSED_W{1'b1}};
        if (pick < 50) return ELAPSED_W'($urandom_range(255));
        return ELAPSED_W'($urandom);
    endfunction

    // lean on the overflow code so that flushes end low power often
    function automatic logic [CODE_W-1:0] rand_flush();
        if ($urandom_range(99) < 40) return ovf_now;
        return CODE_W'($urandom);
    endfunction

    task automatic send_step(input logic [REQ_W-1:0] req, input logic tx,
                             input logic [CODE_W-1:0] rd_code,
                             input logic [CODE_W-1:0] fl_code,
                             input logic [ELAPSED_W-1:0] el);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            @(negedge clk);
            s_valid <= 1'b0;
            repeat ($urandom_range(2)) @(negedge clk);
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_user  <= req;
        s_data  <= {7'd0, el, fl_code, rd_code, tx};
        do @(posedge clk); while (!s_ready);
        steps_sent++;
    endtask

    task automatic send_noise_step();
        logic [REQ_W-1:0] req;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 45)      req = REQ_NONE;
        else if (pick < 55) req = REQ_READ;
        else if (pick < 65) req = REQ_IDLE;
        else if (pick < 74) req = REQ_LPEN;
        else if (pick < 84) req = REQ_LPEX;
        else if (pick < 94) req = REQ_RESET;
        else                req = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        send_step(req, $urandom_range(99) < 60, CODE_W'($urandom), rand_flush(),
                  rand_elapsed());
    endtask

    // idle, sleep, wake and run out the wake delay, then back to reading
    task automatic power_cycle();
        send_step(REQ_IDLE, 1'($urandom_range(1)), CODE_W'($urandom), rand_flush(),
                  rand_elapsed());
        send_step(REQ_LPEN, 1'($urandom_range(1)), CODE_W'($urandom), rand_flush(),
                  rand_elapsed());
        send_step(REQ_NONE, 1'($urandom_range(1)), CODE_W'($urandom), rand_flush(),
                  rand_elapsed());
        send_step(REQ_LPEX, 1'($urandom_range(1)), CODE_W'($urandom), rand_flush(),
                  rand_elapsed());
        repeat ($urandom_range(9, 2))
            send_step(REQ_NONE, 1'($urandom_range(1)), CODE_W'($urandom), rand_flush(),
                      rand_elapsed());
        send_step(REQ_READ, 1'($urandom_range(1)), CODE_W'($urandom), rand_flush(),
                  rand_elapsed());
    endtask

    task automatic run_random(input int count);
        int stop;
        stop = steps_sent + count;
        while (steps_sent < stop) begin
            if ($urandom_range(99) < 35) power_cycle();
            else send_noise_step();
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // upper data bits beyond each register's width are random filler
    task automatic write_config(input logic [STATUS_W-1:0] mask,
                                input logic [ACCUM_W-1:0] delay,
                                input logic [CODE_W-1:0] ovf);
        logic [CFG_DATA_W-1:0] filler;
        filler = CFG_DATA_W'($urandom);
        write_reg(CFG_FAULT_MASK, {filler[CFG_DATA_W-1:STATUS_W], mask});
        write_reg(CFG_WAKE_DELAY, delay);
        write_reg(CFG_OVERFLOW, {filler[CFG_DATA_W-1:CODE_W], ovf});
        ovf_now = ovf;
    endtask

    initial begin
        rst_n      = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        s_user     = REQ_NONE;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_FAULT_MASK;
        cfg_data   = '0;
        calm       = 1'b0;
        hold_asked = 0;
        steps_sent = 0;
        ovf_now    = OVERFLOW_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: walk through every state by hand
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b1, 4'd15, 4'd0, 16'd0);
        send_step(REQ_SPARE_LO, 1'b1, 4'd0, 4'd0, 16'd0);
        send_step(REQ_SPARE_HI, 1'b1, 4'd1, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_RESET, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_IDLE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_LPEN, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_LPEX, 1'b0, 4'd0, 4'd4, 16'hFFFF);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd4, 16'hFFFF);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd4, 16'hFFFF);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_RESET, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_READ, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_LPEN, 1'b1, 4'd3, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_LPEX, 1'b1, 4'd0, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b1, 4'd15, 4'd15, 16'hFFFF);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'hFFFF);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd2, 16'hFFFF);

        // everything faults, wake delay expires on every step
        drain();
        write_config(16'hFFFF, '0, 4'd0);
        run_random(300);

        // nothing faults, longest wake delay so the accumulator saturates
        drain();
        write_config(16'h0000, ACCUM_MAX, 4'hF);
        send_step(REQ_RESET, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_IDLE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_LPEN, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_NONE, 1'b0, 4'd0, 4'd0, 16'd0);
        send_step(REQ_LPEX, 1'b0, 4'd0, 4'd0, 16'hFFFF);
        repeat (300)
            send_step(REQ_NONE, 1'($urandom_range(1)), CODE_W'($urandom), rand_flush(),
                      16'hFFFF);
        run_random(60);

        // random settings, first stretch without any idling
        drain();
        write_config(STATUS_W'($urandom), ACCUM_W'($urandom_range(200000)),
                     CODE_W'($urandom));
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        calm = 1'b1;
        run_random(200);
        calm = 1'b0;
        run_random(200);

        // back to reset values; long result hold-off, then a full pause
        drain();
        write_config(FAULT_MASK_RESET, WAKE_DELAY_RESET, OVERFLOW_RESET);
        run_random(100);
        hold_asked++;
        run_random(150);
        drain();
        run_random(150);

        drain();
        write_config(STATUS_W'($urandom), ACCUM_W'($urandom_range(400000)),
                     CODE_W'($urandom));
        run_random(400);

        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
